[hw/rtl/cpg_osc_pkg.sv]
// Package: sizes, register indexes, reset values and the sine table of the oscillator core.
package cpg_osc_pkg;

    // Oscillator count and index width
    localparam int NUM_OSC = 4;
    localparam int OSC_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    // Sine table geometry
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_LEN        = 1 << SINE_TABLE_BITS;

    // Fixed-point constants
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [15:0] HALF_TURN  = 16'd32768;
    localparam logic [15:0] AMP_RESET  = 16'd205;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_SWING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_STANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_FORE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_SIDE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_UP      = 3'd7;

    // Configuration reset values
    localparam logic [15:0] RST_RATE_GAIN   = 16'd256;
    localparam logic [15:0] RST_TARGET_SQ   = 16'd4096;
    localparam logic [15:0] RST_STEP_TIME   = 16'd66;
    localparam logic [15:0] RST_FREQ_SWING  = 16'd512;
    localparam logic [15:0] RST_FREQ_STANCE = 16'd512;
    localparam logic [14:0] RST_AMP_FORE    = 15'd1638;
    localparam logic [14:0] RST_AMP_SIDE    = 15'd0;
    localparam logic [14:0] RST_AMP_UP      = 15'd1638;

    typedef logic [SINE_LEN*16-1:0] sine_tab_t;

    // One first-quarter sine sample, Taylor series to x^11 in Q30
    function automatic logic [15:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        x    = (64'(k) * TWO_PI_Q30 + 64'(SINE_LEN / 2)) >> SINE_TABLE_BITS;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if ((n & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32767)
            q = 64'sd32767;
        return q[15:0];
    endfunction

    // Full table: first half mirrored from the quarter, second half negated
    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        int unsigned half;
        int unsigned quarter;
        logic [15:0] s;
        tab     = '0;
        half    = SINE_LEN / 2;
        quarter = SINE_LEN / 4;
        for (int unsigned k = 0; k <= half; k++)
        begin
            s = quarter_sine((k <= quarter) ? k : half - k);
            tab[k*16 +: 16] = s;
            if (k > 0 && k < half)
                tab[(k+half)*16 +: 16] = 16'(-$signed(s));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[hw/rtl/cpg_oscillator_foot_trajectory_core.sv]
// Top level: four Hopf-style oscillators with foot trajectory on one shared multiplier.
//
// Usage: a transfer on the s_axis channel carries one tick (tdata bit 0). A tick
// of one starts an update of all oscillators; a tick of zero is taken and
// causes nothing. Each update gives one result per leg on m_axis, leg 0
// first, tlast set on the last leg. Results carry phase, amplitude and
// the three foot displacements.
// Sequence: every oscillator steps through one 33x18 signed multiplier and its
// accumulator under the step sequencer, from ST_SQ to ST_OUT, one leg after
// the other. s_axis_tready is high only while the sequencer is idle.
// Stalls: results wait in one output register; if it is still full when the
// next leg is done, the sequencer holds until the receiver takes it. A new
// tick is taken while the last result still waits.
// Reset: rst_n clears registers to their defaults, phases to zero, amplitudes
// to 0.05 and stored rates to zero. The configuration port writes one register
// per cycle with cfg_we; write it only while the core is idle.
module cpg_oscillator_foot_trajectory_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Tick stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [15:0] phase, [31:16] amplitude, [47:32] disp_fore,
                                        // [63:48] disp_side, [79:64] disp_up
    output logic [1:0]  m_axis_tuser,   // [1:0] leg
    output logic        m_axis_tlast
);

    localparam int OW = cpg_osc_pkg::OSC_W;
    localparam int TB = cpg_osc_pkg::SINE_TABLE_BITS;
    localparam logic [OW-1:0] LAST_OSC = OW'(cpg_osc_pkg::NUM_OSC - 1);
    localparam logic [TB-1:0] QUARTER  = TB'(cpg_osc_pkg::SINE_LEN / 4);

    typedef enum logic [4:0]
    {
        ST_IDLE, ST_SQ, ST_DIFF, ST_DR, ST_GLO, ST_GHI, ST_SUM, ST_RND, ST_ASUM,
        ST_AMUL, ST_AUPD, ST_PMUL, ST_PUPD, ST_FORE, ST_SIDE, ST_UP, ST_OUT
    } state_t;

    // Configuration registers
    logic [15:0] rate_gain_reg, target_sq_reg, step_time_reg, freq_swing_reg, freq_stance_reg;
    logic [14:0] amp_fore_reg, amp_side_reg, amp_up_reg;

    // Oscillator state
    logic        [15:0] phase_reg    [cpg_osc_pkg::NUM_OSC];
    logic signed [15:0] amp_reg      [cpg_osc_pkg::NUM_OSC];
    logic signed [31:0] amp_rate_reg [cpg_osc_pkg::NUM_OSC];
    logic        [15:0] ph_rate_reg  [cpg_osc_pkg::NUM_OSC];

    // Sequencer and output register
    state_t        state_reg, state_next;
    logic [OW-1:0] osc_reg;
    logic          out_valid_reg;
    logic [1:0]    out_leg_reg;
    logic          out_last_reg;
    logic [15:0]   out_phase_reg, out_amp_reg, out_fore_reg, out_side_reg, out_up_reg;

    // Working registers of the shared unit
    logic signed [50:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [32:0] t_reg;
    logic signed [31:0] ar_reg;
    logic        [15:0] pr_reg;
    logic        [15:0] fore_reg, side_reg;

    logic               tick_start;
    logic               can_load;
    logic               is_mul;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic        [15:0] cur_phase;
    logic signed [15:0] cur_amp;
    logic [TB-1:0]      sin_idx, cos_idx;
    logic signed [15:0] sin_val, cos_val;
    logic signed [63:0] acc_rnd;
    logic signed [50:0] da_rnd;
    logic signed [33:0] da;
    logic signed [34:0] amp_sum;
    logic signed [15:0] amp_new;
    logic        [34:0] inc_rnd;
    logic        [15:0] up_disp;

    // Round Q30 product to Q15, half away from zero, keep 16 bits
    function automatic logic [15:0] rnd15(input logic signed [50:0] p);
        logic signed [31:0] v;
        v = p[31:0] + (p[50] ? 32'sd16383 : 32'sd16384);
        return v[30:15];
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign tick_start    = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign can_load      = !out_valid_reg || m_axis_tready;

    assign cur_phase = phase_reg[osc_reg];
    assign cur_amp   = amp_reg[osc_reg];

    // Sine and cosine lookup from the updated phase
    assign sin_idx = cur_phase[15 -: TB];
    assign cos_idx = sin_idx + QUARTER;
    assign sin_val = $signed(cpg_osc_pkg::SINE_TAB[{sin_idx, 4'b0000} +: 16]);
    assign cos_val = $signed(cpg_osc_pkg::SINE_TAB[{cos_idx, 4'b0000} +: 16]);

    // Operand select for the shared multiplier
    always_comb
    begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = 33'(cur_amp);
                mul_b = 18'(cur_amp);
            end
            ST_DR:
            begin
                mul_a = t_reg;
                mul_b = 18'(cur_amp);
            end
            ST_GLO:
            begin
                mul_a = $signed({9'b0, prod_reg[23:0]});
                mul_b = $signed({2'b00, rate_gain_reg});
            end
            ST_GHI:
            begin
                mul_a = t_reg;
                mul_b = $signed({2'b00, rate_gain_reg});
            end
            ST_AMUL, ST_PMUL:
            begin
                mul_a = t_reg;
                mul_b = $signed({2'b00, step_time_reg});
            end
            ST_FORE:
            begin
                mul_a = $signed({18'b0, amp_fore_reg});
                mul_b = 18'(cos_val);
            end
            ST_SIDE:
            begin
                mul_a = $signed({18'b0, amp_side_reg});
                mul_b = osc_reg[0] ? -18'(cos_val) : 18'(cos_val);
            end
            ST_UP:
            begin
                mul_a = $signed({18'b0, amp_up_reg});
                mul_b = 18'(sin_val);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    // Rounding of the rates and steps, saturation of the new amplitude
    always_comb
    begin
        acc_rnd = acc_reg + (acc_reg[63] ? 64'sd2147483647 : 64'sd2147483648);
        da_rnd  = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd65536);
        da      = da_rnd[50:17];
        amp_sum = 35'(cur_amp) + 35'(da);
        if (amp_sum > 35'sd32767)
            amp_new = 16'sh7fff;
        else if (amp_sum < -35'sd32768)
            amp_new = -16'sh8000;
        else
            amp_new = amp_sum[15:0];
        inc_rnd = prod_reg[34:0] + 35'd256;
        up_disp = rnd15(prod_reg);
    end

    // Step sequence per oscillator
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = tick_start ? ST_SQ : ST_IDLE;
            ST_SQ:   state_next = ST_DIFF;
            ST_DIFF: state_next = ST_DR;
            ST_DR:   state_next = ST_GLO;
            ST_GLO:  state_next = ST_GHI;
            ST_GHI:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_RND;
            ST_RND:  state_next = ST_ASUM;
            ST_ASUM: state_next = ST_AMUL;
            ST_AMUL: state_next = ST_AUPD;
            ST_AUPD: state_next = ST_PMUL;
            ST_PMUL: state_next = ST_PUPD;
            ST_PUPD: state_next = ST_FORE;
            ST_FORE: state_next = ST_SIDE;
            ST_SIDE: state_next = ST_UP;
            ST_UP:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!can_load)
                    state_next = ST_OUT;
                else if (osc_reg == LAST_OSC)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SQ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_gain_reg   <= cpg_osc_pkg::RST_RATE_GAIN;
            target_sq_reg   <= cpg_osc_pkg::RST_TARGET_SQ;
            step_time_reg   <= cpg_osc_pkg::RST_STEP_TIME;
            freq_swing_reg  <= cpg_osc_pkg::RST_FREQ_SWING;
            freq_stance_reg <= cpg_osc_pkg::RST_FREQ_STANCE;
            amp_fore_reg    <= cpg_osc_pkg::RST_AMP_FORE;
            amp_side_reg    <= cpg_osc_pkg::RST_AMP_SIDE;
            amp_up_reg      <= cpg_osc_pkg::RST_AMP_UP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpg_osc_pkg::REG_RATE_GAIN:   rate_gain_reg   <= cfg_wdata;
                cpg_osc_pkg::REG_TARGET_SQ:   target_sq_reg   <= cfg_wdata;
                cpg_osc_pkg::REG_STEP_TIME:   step_time_reg   <= cfg_wdata;
                cpg_osc_pkg::REG_FREQ_SWING:  freq_swing_reg  <= cfg_wdata;
                cpg_osc_pkg::REG_FREQ_STANCE: freq_stance_reg <= cfg_wdata;
                cpg_osc_pkg::REG_AMP_FORE:    amp_fore_reg    <= cfg_wdata[14:0];
                cpg_osc_pkg::REG_AMP_SIDE:    amp_side_reg    <= cfg_wdata[14:0];
                cpg_osc_pkg::REG_AMP_UP:      amp_up_reg      <= cfg_wdata[14:0];
            endcase
        end
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            osc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_leg_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_phase_reg <= '0;
            out_amp_reg   <= '0;
            out_fore_reg  <= '0;
            out_side_reg  <= '0;
            out_up_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && can_load)
            begin
                out_valid_reg <= 1'b1;
                out_leg_reg   <= 2'(osc_reg);
                out_last_reg  <= (osc_reg == LAST_OSC);
                out_phase_reg <= cur_phase;
                out_amp_reg   <= cur_amp;
                out_fore_reg  <= fore_reg;
                out_side_reg  <= side_reg;
                out_up_reg    <= up_disp;
                osc_reg       <= (osc_reg == LAST_OSC) ? '0 : OW'(osc_reg + 1'b1);
            end
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Update oscillator state of the current leg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpg_osc_pkg::NUM_OSC; i++)
            begin
                phase_reg[i]    <= '0;
                amp_reg[i]      <= cpg_osc_pkg::AMP_RESET;
                amp_rate_reg[i] <= '0;
                ph_rate_reg[i]  <= '0;
            end
        end
        else if (state_reg == ST_AUPD)
        begin
            amp_reg[osc_reg]      <= amp_new;
            amp_rate_reg[osc_reg] <= ar_reg;
        end
        else if (state_reg == ST_PUPD)
        begin
            phase_reg[osc_reg]   <= cur_phase + inc_rnd[24:9];
            ph_rate_reg[osc_reg] <= pr_reg;
        end
    end

    // Shared multiplier, accumulator and temporaries
    always_ff @(posedge clk)
    begin
        if (is_mul)
            prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_SQ:   pr_reg   <= (cur_phase > cpg_osc_pkg::HALF_TURN) ? freq_stance_reg
                                                                      : freq_swing_reg;
            ST_DIFF: t_reg    <= $signed({5'b0, target_sq_reg, 12'b0}) - $signed(prod_reg[32:0]);
            ST_GLO:  t_reg    <= $signed({{6{prod_reg[50]}}, prod_reg[50:24]});
            ST_GHI:  acc_reg  <= 64'(prod_reg);
            ST_SUM:  acc_reg  <= acc_reg + $signed({prod_reg[39:0], 24'b0});
            ST_RND:  ar_reg   <= acc_rnd[63:32];
            ST_ASUM: t_reg    <= 33'(ar_reg) + 33'(amp_rate_reg[osc_reg]);
            ST_AUPD: t_reg    <= $signed({17'b0, ph_rate_reg[osc_reg]}) + $signed({17'b0, pr_reg});
            ST_SIDE: fore_reg <= rnd15(prod_reg);
            ST_UP:   side_reg <= rnd15(prod_reg);
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_up_reg, out_side_reg, out_fore_reg, out_amp_reg, out_phase_reg};
    assign m_axis_tuser  = out_leg_reg;
    assign m_axis_tlast  = out_last_reg;

    // A tick of one starts the sequence at the first leg
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_start |=> (state_reg == ST_SQ) && (osc_reg == '0))
        else $error("tick did not start sequence at leg 0");

    // Leg counter rests at zero while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (osc_reg == '0))
        else $error("leg counter not cleared when idle");

    // A waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && out_valid_reg && !m_axis_tready |=> (state_reg == ST_OUT))
        else $error("sequencer left output step while result waits");

    // tlast marks exactly the last leg
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_leg_reg == 2'(LAST_OSC))))
        else $error("tlast does not match leg index");

endmodule

[sim/cpg_oscillator_foot_trajectory_core_test.sv]
// Self-checking testbench for the four-leg oscillator core with foot trajectory output.
module cpg_oscillator_foot_trajectory_core_test;

    localparam int REG_COUNT = 8;
    localparam int IDLE_TAIL = 100;

    // One expected leg result
    typedef struct packed {
        logic [1:0]  leg;
        logic [15:0] phase;
        logic [15:0] amplitude;
        logic [15:0] disp_fore;
        logic [15:0] disp_side;
        logic [15:0] disp_up;
        logic        last;
    } leg_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [0] tick, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // [15:0] phase, [31:16] amplitude, [47:32] disp_fore,
                                       // [63:48] disp_side, [79:64] disp_up
    logic [1:0]  m_axis_tuser;         // [1:0] leg
    logic        m_axis_tlast;

    // Mirror of the oscillator state and register file
    logic [15:0]        gait_regs       [REG_COUNT];
    logic [15:0]        gait_phase      [cpg_osc_pkg::NUM_OSC];
    logic signed [15:0] gait_amp        [cpg_osc_pkg::NUM_OSC];
    logic signed [31:0] gait_rate_amp   [cpg_osc_pkg::NUM_OSC];
    logic [15:0]        gait_rate_phase [cpg_osc_pkg::NUM_OSC];
    logic signed [15:0] sine_lut        [cpg_osc_pkg::SINE_LEN];

    leg_result_t legs_due[$];
    int          fail_count   = 0;
    int unsigned ready_hold   = 0;
    bit          tx_no_stall  = 1'b0;
    bit          rx_no_stall  = 1'b0;

    cpg_oscillator_foot_trajectory_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Shift right by n, rounding half away from zero
    function automatic longint round_shift(input longint v, input int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q0.15 amplitude times Q1.15 table entry
    function automatic logic [15:0] scale_q15(input longint amp, input longint entry);
        longint p;
        p = round_shift(amp * entry, 15);
        return p[15:0];
    endfunction

    // Gap length: mostly short, now and then long
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance every oscillator by one step and queue its leg result
    task automatic advance_gait();
        longint      gain, target, dt, r, d, ar, pr, da, inc, prev_ar, prev_pr, c;
        int unsigned idx, cidx;
        leg_result_t res;
        gain   = gait_regs[cpg_osc_pkg::REG_RATE_GAIN];
        target = gait_regs[cpg_osc_pkg::REG_TARGET_SQ];
        dt     = gait_regs[cpg_osc_pkg::REG_STEP_TIME];
        for (int i = 0; i < cpg_osc_pkg::NUM_OSC; i++)
        begin
            r       = gait_amp[i];
            prev_ar = gait_rate_amp[i];
            prev_pr = gait_rate_phase[i];
            d       = (target <<< 12) - r * r;
            ar      = clip(round_shift(gain * d * r, 32), -(64'sd1 <<< 31),
                           (64'sd1 <<< 31) - 1);
            // exactly half a turn still counts as swing
            pr      = (gait_phase[i] > cpg_osc_pkg::HALF_TURN)
                      ? gait_regs[cpg_osc_pkg::REG_FREQ_STANCE]
                      : gait_regs[cpg_osc_pkg::REG_FREQ_SWING];
            inc     = (prev_pr + pr) * dt;
            da      = round_shift((prev_ar + ar) * dt, 17);

            gait_phase[i]      = gait_phase[i] + 16'((inc + 256) >>> 9);
            gait_amp[i]        = 16'(clip(r + da, -32768, 32767));
            gait_rate_amp[i]   = 32'(ar);
            gait_rate_phase[i] = 16'(pr);

            idx  = gait_phase[i] >> (16 - cpg_osc_pkg::SINE_TABLE_BITS);
            cidx = (idx + cpg_osc_pkg::SINE_LEN / 4) % cpg_osc_pkg::SINE_LEN;
            c    = sine_lut[cidx];

            res.leg       = 2'(i);
            res.phase     = gait_phase[i];
            res.amplitude = gait_amp[i];
            res.disp_fore = scale_q15(gait_regs[cpg_osc_pkg::REG_AMP_FORE], c);
            // side sign is plus on even legs, minus on odd legs
            res.disp_side = scale_q15(gait_regs[cpg_osc_pkg::REG_AMP_SIDE],
                                      (i % 2 == 1) ? -c : c);
            res.disp_up   = scale_q15(gait_regs[cpg_osc_pkg::REG_AMP_UP], sine_lut[idx]);
            res.last      = (i == cpg_osc_pkg::NUM_OSC - 1);
            legs_due.insert(legs_due.size(), res);
        end
    endtask

    // Write one register and mirror it, masked to the register width
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == cpg_osc_pkg::REG_AMP_FORE || idx == cpg_osc_pkg::REG_AMP_SIDE ||
            idx == cpg_osc_pkg::REG_AMP_UP)
            gait_regs[idx] = value & 16'h7FFF;
        else
            gait_regs[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Send one tick transfer; predict once it is taken
    task automatic send_tick(input logic tick_bit);
        int unsigned gap;
        gap = tx_no_stall ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tick_bit};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (tick_bit)
            advance_gait();
    endtask

    // Drop valid, drain all expected results, then let the core settle
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (legs_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Land one tick exactly on half a turn, then step on from there
    task automatic test_half_turn();
        write_reg(cpg_osc_pkg::REG_STEP_TIME, 16'd32768);
        write_reg(cpg_osc_pkg::REG_FREQ_STANCE, 16'd1536);
        write_reg(cpg_osc_pkg::REG_AMP_SIDE, 16'd1000);
        send_tick(1'b1);
        wait_until_idle();
        write_reg(cpg_osc_pkg::REG_STEP_TIME, 16'd100);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_until_idle();
    endtask

    // Clear ticks must leave the state alone and give nothing
    task automatic test_tick_clear();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_until_idle();
    endtask

    // Zero step time: rates move on, phase and amplitude hold
    task automatic test_zero_step();
        write_reg(cpg_osc_pkg::REG_STEP_TIME, 16'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_until_idle();
    endtask

    // Drive the amplitude into both saturation limits at full scale
    task automatic test_saturation();
        write_reg(cpg_osc_pkg::REG_RATE_GAIN, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_TARGET_SQ, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_STEP_TIME, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_FREQ_SWING, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_FREQ_STANCE, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_AMP_FORE, 16'hFFFF);
        write_reg(cpg_osc_pkg::REG_AMP_SIDE, 16'h7FFF);
        write_reg(cpg_osc_pkg::REG_AMP_UP, 16'h7FFF);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_until_idle();
    endtask

    // Every register at zero
    task automatic test_all_zero();
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(3'(k), 16'h0000);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_until_idle();
    endtask

    // Random settings, each followed by a run of ticks with some clear ticks mixed in
    task automatic test_random_gait();
        int ticks;
        for (int p = 0; p < 6; p++)
        begin
            for (int k = 0; k < REG_COUNT; k++)
                write_reg(3'(k), pick_setting());
            tx_no_stall = (p == 2);
            rx_no_stall = (p == 2);
            ticks = 0;
            while (ticks < 16)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_tick(1'b0);
                else
                begin
                    send_tick(1'b1);
                    ticks++;
                end
            end
            wait_until_idle();
        end
        tx_no_stall = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // Toggle result ready in runs of random length
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            m_axis_tready <= rx_no_stall || ($urandom_range(0, 2) != 0);
            ready_hold    <= pick_gap();
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        leg_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (legs_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got leg %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = legs_due.pop_front();
                check_field("leg", 16'(want.leg), 16'(m_axis_tuser));
                check_field("phase", want.phase, m_axis_tdata[15:0]);
                check_field("amplitude", want.amplitude, m_axis_tdata[31:16]);
                check_field("disp_fore", want.disp_fore, m_axis_tdata[47:32]);
                check_field("disp_side", want.disp_side, m_axis_tdata[63:48]);
                check_field("disp_up", want.disp_up, m_axis_tdata[79:64]);
                check_field("last", 16'(want.last), 16'(m_axis_tlast));
            end
        end
    end

    initial
    begin : stimulus
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        int unsigned     src;

        // Build the sine table: Taylor series on the first quarter, then mirror
        for (int k = 0; k <= cpg_osc_pkg::SINE_LEN / 2; k++)
        begin
            src  = (k <= cpg_osc_pkg::SINE_LEN / 4) ? k : cpg_osc_pkg::SINE_LEN / 2 - k;
            x    = (64'(src) * cpg_osc_pkg::TWO_PI_Q30 + 64'(cpg_osc_pkg::SINE_LEN / 2))
                   >> cpg_osc_pkg::SINE_TABLE_BITS;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(2 * n * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 16384) >>> 15;
            if (sum > 32767)
                sum = 32767;
            sine_lut[k] = 16'(sum);
            if (k > 0 && k < cpg_osc_pkg::SINE_LEN / 2)
                sine_lut[k + cpg_osc_pkg::SINE_LEN / 2] = 16'(-sum);
        end

        // Reset state of the mirror
        gait_regs[cpg_osc_pkg::REG_RATE_GAIN]   = 16'd256;
        gait_regs[cpg_osc_pkg::REG_TARGET_SQ]   = 16'd4096;
        gait_regs[cpg_osc_pkg::REG_STEP_TIME]   = 16'd66;
        gait_regs[cpg_osc_pkg::REG_FREQ_SWING]  = 16'd512;
        gait_regs[cpg_osc_pkg::REG_FREQ_STANCE] = 16'd512;
        gait_regs[cpg_osc_pkg::REG_AMP_FORE]    = 16'd1638;
        gait_regs[cpg_osc_pkg::REG_AMP_SIDE]    = 16'd0;
        gait_regs[cpg_osc_pkg::REG_AMP_UP]      = 16'd1638;
        for (int i = 0; i < cpg_osc_pkg::NUM_OSC; i++)
        begin
            gait_phase[i]      = '0;
            gait_amp[i]        = 16'sd205;
            gait_rate_amp[i]   = '0;
            gait_rate_phase[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_half_turn();
        test_tick_clear();
        test_zero_step();
        test_saturation();
        test_all_zero();
        test_random_gait();

        wait_until_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop for a hung run
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hw/rtl/cpg_osc_pkg.sv
hw/rtl/cpg_oscillator_foot_trajectory_core.sv
sim/cpg_oscillator_foot_trajectory_core_test.sv
